/* rtl/core/lfusr_pkg.sv */
`default_nettype none

package lfusr_pkg;

    // Slot row geometry and field widths.
    localparam int MAX_SLOTS = 16;
    localparam int SLOT_W    = 4;
    localparam int IDENT_W   = 8;
    localparam int COUNT_W   = 16;
    localparam int STAMP_W   = 32;
    localparam int LIMIT_W   = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(MAX_SLOTS);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [STAMP_W-1:0] STAMP_MAX   = '1;

    // Search token that walks the cell row, one cell per cycle.
    typedef struct packed {
        logic               active;
        logic [IDENT_W-1:0] ident;
        logic               hit;
        logic [SLOT_W-1:0]  hit_slot;
        logic [COUNT_W-1:0] hit_count;
        logic               free_found;
        logic [SLOT_W-1:0]  free_slot;
        logic               vic_found;
        logic [SLOT_W-1:0]  vic_slot;
        logic [COUNT_W-1:0] vic_count;
        logic [STAMP_W-1:0] vic_stamp;
        logic [IDENT_W-1:0] vic_ident;
    } token_t;

    // Slot update broadcast from the controller to the cell row.
    typedef struct packed {
        logic               en;
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic [IDENT_W-1:0] ident;
        logic [COUNT_W-1:0] count;
        logic [STAMP_W-1:0] stamp;
    } slot_wr_t;

endpackage

`default_nettype wire

/* rtl/core/lfu_slot_replacement.sv */
`default_nettype none

// Least-frequently-used slot replacement over 16 slots. Each request names
// an identifier; the result tells whether it was already held, the slot that
// now holds it, any identifier evicted to make room, and its new use count.
// On a miss the lowest free slot is used while fewer than slots_in_use slots
// are occupied (0 acts as 1, values above 16 act as 16); otherwise the
// occupant with the lowest count is evicted, the oldest arrival and then the
// lower slot breaking ties. A request is taken only while idle: a search
// token walks the row of 16 slot cells at one cell per cycle, then the
// target is picked and its cell updated, and the result then loads the
// output register, where it may wait while the next request is accepted.
// The user writes slots_in_use through cfg_wr_en and cfg_wr_data only while
// no request is in flight; the block itself does not enforce this.
module lfu_slot_replacement (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [lfusr_pkg::LIMIT_W-1:0] cfg_wr_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [lfusr_pkg::IDENT_W-1:0] ident,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               was_hit,
    output logic [lfusr_pkg::SLOT_W-1:0]       slot,
    output logic                               evicted_valid,
    output logic [lfusr_pkg::IDENT_W-1:0]      evicted_ident,
    output logic [lfusr_pkg::COUNT_W-1:0]      new_count
);

    lfusr_pkg::token_t   tok [0:lfusr_pkg::MAX_SLOTS];
    lfusr_pkg::slot_wr_t wr;

    // A fresh token enters the first cell on the accepting edge.
    always_comb
    begin
        tok[0]        = '0;
        tok[0].active = in_valid && !in_stall;
        tok[0].ident  = ident;
    end

    // Row of slot cells, each passing the token to its neighbor.
    for (genvar i = 0; i < lfusr_pkg::MAX_SLOTS; i++)
    begin : g_cell
        lfusr_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (lfusr_pkg::SLOT_W'(i)),
            .tok_in   (tok[i]),
            .wr       (wr),
            .tok_out  (tok[i+1])
        );
    end

    lfusr_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .tok_last      (tok[lfusr_pkg::MAX_SLOTS]),
        .wr            (wr),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .was_hit       (was_hit),
        .slot          (slot),
        .evicted_valid (evicted_valid),
        .evicted_ident (evicted_ident),
        .new_count     (new_count)
    );

endmodule

`default_nettype wire

/* rtl/core/lfusr_cell.sv */
`default_nettype none

module lfusr_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [lfusr_pkg::SLOT_W-1:0] cell_idx,
    input  wire lfusr_pkg::token_t           tok_in,
    input  wire lfusr_pkg::slot_wr_t         wr,
    output lfusr_pkg::token_t                tok_out
);

    logic                          valid_reg;
    logic [lfusr_pkg::IDENT_W-1:0] ident_reg;
    logic [lfusr_pkg::COUNT_W-1:0] count_reg;
    logic [lfusr_pkg::STAMP_W-1:0] stamp_reg;
    lfusr_pkg::token_t             tok_reg;
    lfusr_pkg::token_t             tok_next;
    logic                          wr_sel;

    assign wr_sel  = wr.en && (wr.slot == cell_idx);
    assign tok_out = tok_reg;

    // Fold this slot into the running search result.
    always_comb
    begin
        tok_next = tok_in;
        if (!tok_in.hit && valid_reg && (ident_reg == tok_in.ident))
        begin
            tok_next.hit       = 1'b1;
            tok_next.hit_slot  = cell_idx;
            tok_next.hit_count = count_reg;
        end
        if (!tok_in.free_found && !valid_reg)
        begin
            tok_next.free_found = 1'b1;
            tok_next.free_slot  = cell_idx;
        end
        // Strict compares keep the lower slot on a full tie.
        if (valid_reg && (!tok_in.vic_found || (count_reg < tok_in.vic_count) ||
            ((count_reg == tok_in.vic_count) && (stamp_reg < tok_in.vic_stamp))))
        begin
            tok_next.vic_found = 1'b1;
            tok_next.vic_slot  = cell_idx;
            tok_next.vic_count = count_reg;
            tok_next.vic_stamp = stamp_reg;
            tok_next.vic_ident = ident_reg;
        end
    end

    // Token stage toward the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    // Slot contents; only the valid bit is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_sel)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_sel)
        begin
            ident_reg <= wr.ident;
            count_reg <= wr.count;
            if (!wr.hit)
            begin
                stamp_reg <= wr.stamp;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/lfusr_ctrl.sv */
`default_nettype none

module lfusr_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [lfusr_pkg::LIMIT_W-1:0] cfg_wr_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire lfusr_pkg::token_t             tok_last,
    output lfusr_pkg::slot_wr_t                wr,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               was_hit,
    output logic [lfusr_pkg::SLOT_W-1:0]       slot,
    output logic                               evicted_valid,
    output logic [lfusr_pkg::IDENT_W-1:0]      evicted_ident,
    output logic [lfusr_pkg::COUNT_W-1:0]      new_count
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t                        state_reg;
    logic [lfusr_pkg::LIMIT_W-1:0] limit_reg;
    logic [lfusr_pkg::LIMIT_W-1:0] occupied_reg;
    logic [lfusr_pkg::LIMIT_W-1:0] occupied_next;
    logic [lfusr_pkg::STAMP_W-1:0] arrival_reg;
    logic [lfusr_pkg::STAMP_W-1:0] stamp_now_reg;
    logic [lfusr_pkg::LIMIT_W-1:0] eff_limit;
    logic                          accept;
    logic                          done;
    logic                          out_load;

    // Pending result, held until the output register is free.
    logic                          res_hit_reg;
    logic [lfusr_pkg::SLOT_W-1:0]  res_slot_reg;
    logic                          res_ev_reg;
    logic [lfusr_pkg::IDENT_W-1:0] res_ev_ident_reg;
    logic [lfusr_pkg::COUNT_W-1:0] res_count_reg;

    logic                          out_valid_reg;
    logic                          was_hit_reg;
    logic [lfusr_pkg::SLOT_W-1:0]  slot_reg;
    logic                          evicted_valid_reg;
    logic [lfusr_pkg::IDENT_W-1:0] evicted_ident_reg;
    logic [lfusr_pkg::COUNT_W-1:0] new_count_reg;

    logic                          dec_ev;
    logic [lfusr_pkg::IDENT_W-1:0] dec_ev_ident;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);
    assign done     = (state_reg == ST_SCAN) && tok_last.active;
    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);

    assign out_valid     = out_valid_reg;
    assign was_hit       = was_hit_reg;
    assign slot          = slot_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_ident = evicted_ident_reg;
    assign new_count     = new_count_reg;

    // Clamp the configured limit into 1..MAX_SLOTS.
    always_comb
    begin
        if (limit_reg == '0)
        begin
            eff_limit = lfusr_pkg::LIMIT_W'(1);
        end
        else if (limit_reg > lfusr_pkg::LIMIT_W'(lfusr_pkg::MAX_SLOTS))
        begin
            eff_limit = lfusr_pkg::LIMIT_W'(lfusr_pkg::MAX_SLOTS);
        end
        else
        begin
            eff_limit = limit_reg;
        end
    end

    // Pick the target slot once the token leaves the last cell.
    always_comb
    begin
        wr            = '0;
        wr.en         = done;
        wr.ident      = tok_last.ident;
        wr.stamp      = stamp_now_reg;
        wr.count      = lfusr_pkg::COUNT_W'(1);
        occupied_next = occupied_reg;
        dec_ev        = 1'b0;
        dec_ev_ident  = '0;
        if (tok_last.hit)
        begin
            wr.hit  = 1'b1;
            wr.slot = tok_last.hit_slot;
            if (tok_last.hit_count != lfusr_pkg::COUNT_MAX)
            begin
                wr.count = tok_last.hit_count + lfusr_pkg::COUNT_W'(1);
            end
            else
            begin
                wr.count = tok_last.hit_count;
            end
        end
        else if ((occupied_reg < eff_limit) && tok_last.free_found)
        begin
            wr.slot       = tok_last.free_slot;
            occupied_next = occupied_reg + lfusr_pkg::LIMIT_W'(1);
        end
        else if (tok_last.vic_found)
        begin
            wr.slot      = tok_last.vic_slot;
            dec_ev       = 1'b1;
            dec_ev_ident = tok_last.vic_ident;
        end
        else
        begin
            // No occupant at all: slot zero is taken as free.
            wr.slot       = '0;
            occupied_next = occupied_reg + lfusr_pkg::LIMIT_W'(1);
        end
    end

    // Sequencer, counters and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= lfusr_pkg::LIMIT_RESET;
            occupied_reg  <= '0;
            arrival_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        stamp_now_reg <= arrival_reg;
                        if (arrival_reg != lfusr_pkg::STAMP_MAX)
                        begin
                            arrival_reg <= arrival_reg + lfusr_pkg::STAMP_W'(1);
                        end
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (done)
                    begin
                        occupied_reg     <= occupied_next;
                        res_hit_reg      <= tok_last.hit;
                        res_slot_reg     <= wr.slot;
                        res_ev_reg       <= dec_ev;
                        res_ev_ident_reg <= dec_ev_ident;
                        res_count_reg    <= wr.count;
                        state_reg        <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_load)
                    begin
                        was_hit_reg       <= res_hit_reg;
                        slot_reg          <= res_slot_reg;
                        evicted_valid_reg <= res_ev_reg;
                        evicted_ident_reg <= res_ev_ident_reg;
                        new_count_reg     <= res_count_reg;
                        state_reg         <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/lfusr_checker.sv */
`default_nettype none

module lfusr_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic                          was_hit,
    input wire logic [lfusr_pkg::SLOT_W-1:0]  slot,
    input wire logic                          evicted_valid,
    input wire logic [lfusr_pkg::IDENT_W-1:0] evicted_ident,
    input wire logic [lfusr_pkg::COUNT_W-1:0] new_count
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(slot) && $stable(new_count))
        else $error("result changed while stalled");

    // A hit never evicts.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(was_hit && evicted_valid))
        else $error("hit reported with eviction");

    // Without eviction the evicted identifier reads zero.
    a_ev_ident_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted_valid |-> evicted_ident == '0)
        else $error("evicted identifier set without eviction");

    // A newly placed identifier starts at count one.
    a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !was_hit |-> new_count == lfusr_pkg::COUNT_W'(1))
        else $error("miss with count other than one");

    // One request at a time: the block is busy right after accepting.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken while busy");

endmodule

bind lfu_slot_replacement lfusr_checker u_lfusr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .was_hit       (was_hit),
    .slot          (slot),
    .evicted_valid (evicted_valid),
    .evicted_ident (evicted_ident),
    .new_count     (new_count)
);

`default_nettype wire
